@@ hdl/loop_timing_statistics_defines.svh @@
// ---------------------------------------------------------------------------
// Loop timing statistics assertion macros
// Shared concurrent assertion helpers for the statistics block.
// ---------------------------------------------------------------------------
`ifndef LOOP_TIMING_STATISTICS_DEFINES_SVH
`define LOOP_TIMING_STATISTICS_DEFINES_SVH
`ifndef SYNTHESIS
`define LTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/lts_pkg.sv @@
// ---------------------------------------------------------------------------
// Loop timing statistics package
// Payload types, widths and defaults shared by the block.
// ---------------------------------------------------------------------------
package lts_pkg;
  localparam int TS_W = 63;
  localparam int STAT_W = 32;
  localparam int SUM_W = 64;
  localparam int DURATION_WIDTH_DEF = 32;
  localparam int NUM_CFG = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE = 1'b1;
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic            command;
    logic [TS_W-1:0] start_time;
    logic [TS_W-1:0] stop_time;
  } in_item_t;

  typedef struct packed {
    logic              counted;
    logic [STAT_W-1:0] iterations;
    logic [STAT_W-1:0] compute_mean;
    logic [STAT_W-1:0] compute_min;
    logic [STAT_W-1:0] compute_max;
    logic [STAT_W-1:0] period_mean;
    logic [STAT_W-1:0] period_min;
    logic [STAT_W-1:0] period_max;
    logic [STAT_W-1:0] delayed_count;
  } out_item_t;
endpackage

@@ hdl/lts_front.sv @@
// ---------------------------------------------------------------------------
// Loop timing statistics front end
// Accepts beats and reduces timestamps to clamped durations.
// ---------------------------------------------------------------------------
module lts_front
  import lts_pkg::*;
#(
  parameter int DURATION_WIDTH = DURATION_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  output logic                      q_valid,
  input  logic                      q_ready,
  output logic                      q_cmd,
  output logic [DURATION_WIDTH-1:0] q_comp,
  output logic [DURATION_WIDTH-1:0] q_per
);
  localparam logic [TS_W:0] DUR_MAX = {{(TS_W+1-DURATION_WIDTH){1'b0}},
                                       {DURATION_WIDTH{1'b1}}};
  logic [TS_W-1:0] prev_r, prev_nxt;
  logic q_valid_r, q_valid_nxt;
  logic q_cmd_r;
  logic [DURATION_WIDTH-1:0] q_comp_r, q_per_r;
  logic [TS_W:0] dc, dp;
  logic acc;

  assign in_ready = !q_valid_r || q_ready;
  assign acc = in_valid && in_ready;
  assign dc = {1'b0, in_data.stop_time} - {1'b0, in_data.start_time};
  assign dp = {1'b0, in_data.start_time} - {1'b0, prev_r};

  always_comb begin
    prev_nxt = prev_r;
    if (acc && in_data.command == CMD_RECORD) prev_nxt = in_data.start_time;
    q_valid_nxt = q_valid_r;
    if (acc) q_valid_nxt = 1'b1;
    else if (q_ready) q_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      q_valid_r <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      q_valid_r <= q_valid_nxt;
    end
    if (acc) begin
      q_cmd_r <= in_data.command;
      q_comp_r <= dc[TS_W] ? '0 : (dc > DUR_MAX ? '1 : dc[DURATION_WIDTH-1:0]);
      q_per_r <= dp[TS_W] ? '0 : (dp > DUR_MAX ? '1 : dp[DURATION_WIDTH-1:0]);
    end
  end

  assign q_valid = q_valid_r;
  assign q_cmd = q_cmd_r;
  assign q_comp = q_comp_r;
  assign q_per = q_per_r;
endmodule

@@ hdl/lts_divider.sv @@
// ---------------------------------------------------------------------------
// Loop timing statistics divider
// Restoring divider, one quotient bit per cycle, low 32 bits kept.
// ---------------------------------------------------------------------------
module lts_divider
  import lts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [STAT_W-1:0] divisor,
  output logic              done,
  output logic [STAT_W-1:0] quotient
);
  localparam int CNT_W = $clog2(SUM_W + 1);
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [STAT_W:0] rem_r, rem_nxt;
  logic [STAT_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [STAT_W+1:0] sh, diff;

  assign sh = {rem_r, quo_r[SUM_W-1]};
  assign diff = sh - {2'b00, dvs_r};

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[STAT_W+1]) begin
        rem_nxt = diff[STAT_W:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[STAT_W:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done = done_r;
  assign quotient = quo_r[STAT_W-1:0];
endmodule

@@ hdl/lts_back.sv @@
// ---------------------------------------------------------------------------
// Loop timing statistics back end
// Updates the accumulators and forms one result beat per item.
// ---------------------------------------------------------------------------
`include "loop_timing_statistics_defines.svh"
module lts_back
  import lts_pkg::*;
#(
  parameter int DURATION_WIDTH = DURATION_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [STAT_W-1:0]         threshold,
  input  logic [15:0]               ignore_cnt,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  logic                      q_cmd,
  input  logic [DURATION_WIDTH-1:0] q_comp,
  input  logic [DURATION_WIDTH-1:0] q_per,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_DIVC = 4'b0010, S_DIVP = 4'b0100, S_OUT = 4'b1000
  } state_t;
  localparam logic [DURATION_WIDTH-1:0] DONES = '1;

  state_t state_r, state_nxt;
  logic [16:0] skip_r;
  logic [STAT_W-1:0] cnt_r, late_r;
  logic [SUM_W-1:0] csum_r, psum_r;
  logic [DURATION_WIDTH-1:0] clo_r, chi_r, plo_r, phi_r;
  logic counted_r;
  logic [STAT_W-1:0] cmean_r;
  logic div_start, div_done;
  logic [SUM_W-1:0] div_a;
  logic [STAT_W-1:0] div_q;
  logic [SUM_W:0] cs, ps;
  logic take, have;
  out_item_t res;

  assign q_ready = state_r == S_IDLE;
  assign take = q_valid && q_ready;
  assign cs = {1'b0, csum_r} + {{(SUM_W+1-DURATION_WIDTH){1'b0}}, q_comp};
  assign ps = {1'b0, psum_r} + {{(SUM_W+1-DURATION_WIDTH){1'b0}}, q_per};
  assign have = cnt_r != '0;

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_a = csum_r;
    case (state_r)
      S_IDLE: if (take) state_nxt = S_DIVC;
      S_DIVC: begin
        if (!have) state_nxt = S_OUT;
        else begin
          div_start = 1'b1;
          state_nxt = S_DIVP;
        end
      end
      S_DIVP: begin
        div_a = psum_r;
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: if (out_valid && out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      skip_r <= 17'd1;
      cnt_r <= '0;
      late_r <= '0;
      csum_r <= '0;
      psum_r <= '0;
      clo_r <= DONES;
      chi_r <= '0;
      plo_r <= DONES;
      phi_r <= '0;
      counted_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take) begin
        counted_r <= 1'b0;
        if (q_cmd == CMD_CLEAR) begin
          skip_r <= {1'b0, ignore_cnt} + 17'd1;
          cnt_r <= '0;
          late_r <= '0;
          csum_r <= '0;
          psum_r <= '0;
          clo_r <= DONES;
          chi_r <= '0;
          plo_r <= DONES;
          phi_r <= '0;
        end else if (skip_r != '0) begin
          skip_r <= skip_r - 17'd1;
        end else if (cnt_r != '1) begin
          counted_r <= 1'b1;
          cnt_r <= cnt_r + 1'b1;
          csum_r <= cs[SUM_W] ? '1 : cs[SUM_W-1:0];
          psum_r <= ps[SUM_W] ? '1 : ps[SUM_W-1:0];
          if (q_comp < clo_r) clo_r <= q_comp;
          if (q_comp > chi_r) chi_r <= q_comp;
          if (q_per < plo_r) plo_r <= q_per;
          if (q_per > phi_r) phi_r <= q_per;
          if ({{(SUM_W+1-DURATION_WIDTH){1'b0}}, q_per} >
              {{(SUM_W+1-STAT_W){1'b0}}, threshold})
            late_r <= late_r + 1'b1;
        end
      end
    end
    if (state_r == S_DIVP) begin
      if (div_done) cmean_r <= div_q;
    end else if (state_r == S_DIVC) begin
      cmean_r <= '0;
    end
  end

  lts_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(cnt_r), .done(div_done), .quotient(div_q)
  );

  // S_OUT waits for the period quotient (if the count is non-zero), then holds it with the beat
  logic [STAT_W-1:0] pmean_r;
  logic out_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (state_r == S_OUT && (!have || div_done)) out_v_r <= !out_ready;
    else if (out_ready) out_v_r <= 1'b0;
    if (state_r == S_OUT && div_done) pmean_r <= div_q;
    else if (state_r == S_DIVC) pmean_r <= '0;
  end

  always_comb begin
    res.counted = counted_r;
    res.iterations = cnt_r;
    res.compute_mean = cmean_r;
    res.compute_min = have ? STAT_W'(clo_r) : '0;
    res.compute_max = have ? STAT_W'(chi_r) : '0;
    res.period_mean = (state_r == S_OUT && div_done) ? div_q : pmean_r;
    res.period_min = have ? STAT_W'(plo_r) : '0;
    res.period_max = have ? STAT_W'(phi_r) : '0;
    res.delayed_count = late_r;
  end

  assign out_valid = (state_r == S_OUT && (!have || div_done)) || out_v_r;
  assign out_data = res;

  // beat stays offered after a stall until the receiver takes it
  logic held;
  assign held = out_v_r;
  `LTS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `LTS_ASSERT_IMPL(a_noacc, clk, rst_n, state_r != S_IDLE, !q_ready)
  `LTS_ASSERT_IMPL(a_held, clk, rst_n, held, state_r == S_OUT)
  `LTS_ASSERT_IMPL(a_mmx, clk, rst_n, have, clo_r <= chi_r && plo_r <= phi_r)
endmodule

@@ hdl/loop_timing_statistics.sv @@
// Loop timing statistics. Input beats (in_valid/in_ready, in_data) carry a
// command and start/stop timestamps in ns; each beat yields exactly one
// output beat (out_valid/out_ready, out_data) with the running statistics.
// Configuration: cfg_we writes cfg_data into register cfg_index at once
// (0 threshold, 1 ignore count); write only while idle.
// Flow: a front stage clamps durations into a one-entry queue; the back
// stage updates the accumulators and runs two serial 64-step divisions
// for the means on one shared restoring divider.
// Order: front register, back update in S_IDLE, the two divisions (skipped
// while the count is zero), result beat in S_OUT. The back stage takes no
// new item before its result is taken; the front accepts one further item
// meanwhile.
// Reset: synchronous, active low; statistics clear, threshold all ones,
// ignore count 0, previous start 0.
// Stall: when out_ready is low the result is held and the back stage
// waits; the front queue then fills and in_ready drops.
// ---------------------------------------------------------------------------
// Loop timing statistics top level
// Ties the config registers, front end and statistics back end.
// ---------------------------------------------------------------------------
module loop_timing_statistics
  import lts_pkg::*;
#(
  parameter int DURATION_WIDTH = DURATION_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  logic [STAT_W-1:0] thr_r;
  logic [15:0] ign_r;
  logic q_valid, q_ready, q_cmd;
  logic [DURATION_WIDTH-1:0] q_comp, q_per;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '1;
      ign_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r <= cfg_data;
        REG_IGNORE: ign_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  lts_front #(.DURATION_WIDTH(DURATION_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .q_comp(q_comp), .q_per(q_per)
  );

  lts_back #(.DURATION_WIDTH(DURATION_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .threshold(thr_r), .ignore_cnt(ign_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .q_comp(q_comp),
    .q_per(q_per), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );
endmodule

@@ tb/tb_loop_timing_statistics.sv @@
// ---------------------------------------------------------------------------
// Loop timing statistics testbench
// A directed table runs first, then phases of random loop timestamps with
// different threshold and skip settings. Each result beat is checked against
// the in-bench statistics model or a typed row value. Both handshake sides
// idle at random except in the quiet phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_loop_timing_statistics;
  import lts_pkg::*;

  localparam int          DUR_W        = DURATION_WIDTH_DEF;
  localparam logic [63:0] DUR_CAP      = (64'd1 << DUR_W) - 64'd1;
  localparam int          CYCLE_LIMIT  = 3_000_000;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          PHASES       = 8;
  localparam int          PHASE_BEATS  = 200;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    in_item_t              beat;
    bit                    typed;  // use want instead of the model
    out_item_t             want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  loop_timing_statistics #(.DURATION_WIDTH(DUR_W)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---- statistics model state ----
  logic [31:0] thr_reg;
  logic [15:0] skip_reg;
  logic [16:0] skip_left;
  logic [62:0] last_start;
  logic [31:0] n_samples;
  logic [63:0] comp_sum, comp_lo, comp_hi;
  logic [63:0] per_sum, per_lo, per_hi;
  logic [31:0] late_n;

  out_item_t stats_q[$];  // results still owed by the block
  int        err_count = 0;
  bit        quiet = 1'b0;  // no idling on either side
  int        cycles = 0;

  function automatic void clear_stats();
    skip_left = {1'b0, skip_reg} + 17'd1;
    n_samples = '0;
    comp_sum = '0; comp_lo = DUR_CAP; comp_hi = '0;
    per_sum = '0;  per_lo = DUR_CAP;  per_hi = '0;
    late_n = '0;
  endfunction

  // clamped difference, saturated at the duration width
  function automatic logic [63:0] span(logic [62:0] a, logic [62:0] b);
    logic [63:0] d;
    if (a <= b) return '0;
    d = {1'b0, a - b};
    return (d > DUR_CAP) ? DUR_CAP : d;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic out_item_t loop_stats_next(in_item_t it);
    out_item_t   r;
    logic [63:0] comp, per, q;
    r = '0;
    if (it.command == CMD_CLEAR) begin
      clear_stats();
    end else begin
      if (skip_left != 0) begin
        skip_left--;
      end else if (n_samples != '1) begin
        comp = span(it.stop_time, it.start_time);
        per = span(it.start_time, last_start);
        n_samples++;
        comp_sum = add_sat(comp_sum, comp);
        if (comp < comp_lo) comp_lo = comp;
        if (comp > comp_hi) comp_hi = comp;
        per_sum = add_sat(per_sum, per);
        if (per < per_lo) per_lo = per;
        if (per > per_hi) per_hi = per;
        if (per > {32'd0, thr_reg}) late_n++;
        r.counted = 1'b1;
      end
      last_start = it.start_time;
    end
    r.iterations = n_samples;
    r.delayed_count = late_n;
    if (n_samples != 0) begin
      q = comp_sum / n_samples;
      r.compute_mean = q[31:0];
      q = per_sum / n_samples;
      r.period_mean = q[31:0];
      r.compute_min = comp_lo[31:0];
      r.compute_max = comp_hi[31:0];
      r.period_min = per_lo[31:0];
      r.period_max = per_hi[31:0];
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one beat; the model runs at the accepting edge.
  task automatic send_beat(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t p;
    int g;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    p = loop_stats_next(it);
    stats_q.push_back(typed ? want : p);
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Register write, only once every result is back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_THRESHOLD) thr_reg = val;
    else if (idx == REG_IGNORE) skip_reg = val[15:0];
  endtask

  function automatic in_item_t mk(logic cmd, logic [62:0] st, logic [62:0] sp);
    in_item_t it;
    it.command = cmd;
    it.start_time = st;
    it.stop_time = sp;
    return it;
  endfunction

  // ---- result side: random back-pressure and checking ----
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_ready <= rst_n;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      if (stats_q.size() == 0) begin
        $display("[%0t] result beat with nothing expected", $realtime);
        err_count++;
      end else begin
        w = stats_q.pop_front();
        if (out_data.counted !== w.counted) report("counted", out_data.counted, w.counted);
        if (out_data.iterations !== w.iterations)
          report("iterations", out_data.iterations, w.iterations);
        if (out_data.compute_mean !== w.compute_mean)
          report("compute_mean", out_data.compute_mean, w.compute_mean);
        if (out_data.compute_min !== w.compute_min)
          report("compute_min", out_data.compute_min, w.compute_min);
        if (out_data.compute_max !== w.compute_max)
          report("compute_max", out_data.compute_max, w.compute_max);
        if (out_data.period_mean !== w.period_mean)
          report("period_mean", out_data.period_mean, w.period_mean);
        if (out_data.period_min !== w.period_min)
          report("period_min", out_data.period_min, w.period_min);
        if (out_data.period_max !== w.period_max)
          report("period_max", out_data.period_max, w.period_max);
        if (out_data.delayed_count !== w.delayed_count)
          report("delayed_count", out_data.delayed_count, w.delayed_count);
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---- stimulus ----
  initial begin
    dir_row_t    rows[$];
    dir_row_t    row;
    out_item_t   first_stats;
    in_item_t    it;
    logic [62:0] cursor, st, sp, per, comp;
    logic [62:0] ts_max;
    int          r;

    ts_max = '1;
    first_stats = '{1'b1, 32'd1, 32'd100, 32'd100, 32'd100,
                    32'd1000, 32'd1000, 32'd1000, 32'd0};
    row = '{ROW_BEAT, '0, '0, '0, 1'b0, '0};

    // Directed table. After reset: threshold all ones, one iteration skipped.
    row.typed = 1; row.want = '0;
    row.beat = mk(CMD_RECORD, 63'd1000, 63'd1500); rows.push_back(row);   // skipped
    row.want = first_stats;
    row.beat = mk(CMD_RECORD, 63'd2000, 63'd2100); rows.push_back(row);
    row.typed = 0;
    row.beat = mk(CMD_RECORD, 63'd3000, 63'd2000); rows.push_back(row);   // stop before start
    row.beat = mk(CMD_RECORD, 63'd500, 63'd600); rows.push_back(row);     // time going back
    row.beat = mk(CMD_RECORD, 63'd1 << 40, (63'd3 << 40)); rows.push_back(row); // saturate
    row.beat = mk(CMD_RECORD, ts_max, ts_max); rows.push_back(row);
    row.beat = mk(CMD_RECORD, 63'd0, ts_max); rows.push_back(row);
    row.beat = mk(CMD_RECORD, ts_max, 63'd0); rows.push_back(row);
    row.typed = 1; row.want = '0;
    row.beat = mk(CMD_CLEAR, ts_max, ts_max); rows.push_back(row);
    row.beat = mk(CMD_RECORD, 63'd0, 63'd0); rows.push_back(row);
    row.typed = 0;
    row.beat = mk(CMD_RECORD, 63'd5000, 63'd5000); rows.push_back(row);
    row.kind = ROW_CFG;
    row.idx = REG_THRESHOLD; row.val = '0; rows.push_back(row);
    row.idx = REG_IGNORE; row.val = 32'd2; rows.push_back(row);
    row.kind = ROW_BEAT;
    // new skip count waits for a clear; threshold 0 makes every non-zero period late
    row.beat = mk(CMD_RECORD, 63'd6000, 63'd6100); rows.push_back(row);
    row.typed = 1;
    row.beat = mk(CMD_CLEAR, 63'd0, 63'd0); rows.push_back(row);
    row.beat = mk(CMD_RECORD, 63'd7000, 63'd7010); rows.push_back(row);
    row.beat = mk(CMD_RECORD, 63'd8000, 63'd8020); rows.push_back(row);
    row.beat = mk(CMD_RECORD, 63'd9000, 63'd9030); rows.push_back(row);
    row.typed = 0;
    row.beat = mk(CMD_RECORD, 63'd10000, 63'd10040); rows.push_back(row);
    row.kind = ROW_CFG;
    row.idx = REG_IGNORE; row.val = 32'hFFFF; rows.push_back(row);
    row.idx = REG_THRESHOLD; row.val = 32'hFFFF_FFFF; rows.push_back(row);
    row.kind = ROW_BEAT; row.typed = 1;
    row.beat = mk(CMD_CLEAR, 63'd0, 63'd0); rows.push_back(row);
    row.beat = mk(CMD_RECORD, 63'd11000, 63'd11500); rows.push_back(row);
    row.kind = ROW_CFG; row.idx = REG_IGNORE; row.val = '0; rows.push_back(row);
    row.kind = ROW_BEAT;
    row.beat = mk(CMD_CLEAR, 63'd0, 63'd0); rows.push_back(row);
    row.beat = mk(CMD_RECORD, 63'd12000, 63'd12100); rows.push_back(row);

    thr_reg = '1;
    skip_reg = '0;
    last_start = '0;
    clear_stats();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].val);
      else send_beat(rows[i].beat, rows[i].typed, rows[i].want);
    end

    // Random phases, each with its own threshold and skip count.
    cursor = 63'd20000;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: write_reg(REG_THRESHOLD, 32'd0);
        1: write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
        default: write_reg(REG_THRESHOLD, $urandom_range(900, 1100));
      endcase
      write_reg(REG_IGNORE, (ph == 6) ? 32'hFFFF : $urandom_range(0, 4));
      quiet = (ph == 3);
      send_beat(mk(CMD_CLEAR, 63'({$urandom, $urandom}), 63'({$urandom, $urandom})));
      for (int k = 0; k < PHASE_BEATS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          it = mk(CMD_CLEAR, 63'({$urandom, $urandom}), 63'({$urandom, $urandom}));
        end else if (r < 12) begin
          // noise: arbitrary timestamps, all bits exercised
          st = 63'({$urandom, $urandom});
          sp = 63'({$urandom, $urandom});
          it = mk(CMD_RECORD, st, sp);
          cursor = st;
        end else begin
          if (r < 15) per = 63'd1 << $urandom_range(32, 40);  // long stall
          else if (r < 25) per = 63'($urandom_range(1, 5000));
          else per = 63'($urandom_range(900, 1100));
          comp = (r < 18) ? (63'd1 << $urandom_range(32, 36))
                          : 63'($urandom_range(0, 900));
          st = cursor + per;
          sp = st + comp;
          it = mk(CMD_RECORD, st, sp);
          cursor = st;
        end
        send_beat(it);
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (stats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
